FILE: sv/inflated_voxel_occupancy_map_top_defines.svh
// Assertion macros for the inflated voxel occupancy map.
// Included by ivom_map, which checks its own logic; needs clk and rst in scope.
`ifndef INFLATED_VOXEL_OCCUPANCY_MAP_TOP_DEFINES_SVH
`define INFLATED_VOXEL_OCCUPANCY_MAP_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IVOM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IVOM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ivom_pkg.sv
// Shared types and constants of the inflated voxel occupancy map.
// No dependencies; used by ivom_map, the top level and the testbench.
`default_nettype none

package ivom_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR      = 2'd0,
    CMD_INSERT     = 2'd1,
    CMD_QUERY_POS  = 2'd2,
    CMD_QUERY_CELL = 2'd3
  } cmd_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_METRE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_CELLS_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_CELLS_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_CELLS_Z    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INFLATE_CELLS   = 3'd7;

  // Signed cell index wide enough for any scaled Q8.8 offset plus inflation.
  localparam int CELL_W = 18;
  localparam int PROD_W = 26;
  localparam int CNT_W  = 11;
  localparam logic [CNT_W-1:0] MARK_SAT = 11'd2047;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [7:0]  cell_x;
    logic signed [7:0]  cell_y;
    logic signed [7:0]  cell_z;
  } item_in_t;

  typedef struct packed {
    logic             hit;
    logic             outside;
    logic [CNT_W-1:0] cells_marked;
  } item_out_t;

  typedef struct packed {
    logic [7:0]         cells_per_metre;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic [6:0]         grid_cells_x;
    logic [6:0]         grid_cells_y;
    logic [5:0]         grid_cells_z;
    logic [2:0]         inflate_cells;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/inflated_voxel_occupancy_map_top.sv
// Top level of the inflated voxel occupancy map: configuration registers and result register.
// Depends on ivom_pkg and ivom_map.
//
// Use: commands arrive on in_valid/in_stall with an in_item payload; each command gives
// exactly one result transaction on out_valid/out_stall with an out_item payload.
// Configuration registers are written on cfg_valid/cfg_ready (cfg_index, cfg_data) by the
// user only while the block is idle, not enforced by the block; cfg_ready is always high.
// One command is worked on at a time, through these states to the result register:
//   query: S_MUL, S_CELL, S_PLAN (memory read), S_READ; no read for a cell off the grid;
//   insert: the same states; unless below the floor, an S_SWEEP comes before S_READ
//     over the (2*r+1)^2 columns, r the clamped inflation radius, one occupancy-memory column
//     per cycle, all z cells of a column written at once; clear: S_CLEAR, a row per cycle.
// The next command is accepted the cycle after the previous one reaches the result
// register, even while that result is still stalled.
// After rst the block runs the same clearing pass over all memory rows with in_stall
// high; configuration writes are taken during it.
// When the receiver stalls, the result holds in the output register and the block stops
// after finishing at most one more command.
`default_nettype none

module inflated_voxel_occupancy_map_top #(
  parameter int MAX_CELLS_X = 64,
  parameter int MAX_CELLS_Y = 64,
  parameter int MAX_CELLS_Z = 32,
  parameter int INFLATE_MAX = 7,
  parameter int INFLATE_Z   = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ivom_pkg::item_in_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ivom_pkg::item_out_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ivom_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ivom_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ivom_pkg::*;

  cfg_t      cfg;
  logic      req_ready;
  logic      res_valid, res_ready;
  item_out_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cells_per_metre <= 8'd20;
      cfg.origin_x        <= -16'sd3328;
      cfg.origin_y        <= -16'sd2560;
      cfg.origin_z        <= -16'sd256;
      cfg.grid_cells_x    <= 7'd64;
      cfg.grid_cells_y    <= 7'd64;
      cfg.grid_cells_z    <= 6'd32;
      cfg.inflate_cells   <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELLS_PER_METRE: cfg.cells_per_metre <= cfg_data[7:0];
        REG_ORIGIN_X:        cfg.origin_x        <= cfg_data;
        REG_ORIGIN_Y:        cfg.origin_y        <= cfg_data;
        REG_ORIGIN_Z:        cfg.origin_z        <= cfg_data;
        REG_GRID_CELLS_X:    cfg.grid_cells_x    <= cfg_data[6:0];
        REG_GRID_CELLS_Y:    cfg.grid_cells_y    <= cfg_data[6:0];
        REG_GRID_CELLS_Z:    cfg.grid_cells_z    <= cfg_data[5:0];
        REG_INFLATE_CELLS:   cfg.inflate_cells   <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  ivom_map #(
    .MAX_CELLS_X(MAX_CELLS_X),
    .MAX_CELLS_Y(MAX_CELLS_Y),
    .MAX_CELLS_Z(MAX_CELLS_Z),
    .INFLATE_MAX(INFLATE_MAX),
    .INFLATE_Z  (INFLATE_Z)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req_valid(in_valid),
    .req_ready(req_ready),
    .req      (in_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign in_stall  = !req_ready;
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ivom_map.sv
// Occupancy memory and command sequencer of the inflated voxel occupancy map.
// Depends on ivom_pkg and on the assertion macros header.
`default_nettype none
`include "inflated_voxel_occupancy_map_top_defines.svh"

module ivom_map #(
  parameter int MAX_CELLS_X = 64,
  parameter int MAX_CELLS_Y = 64,
  parameter int MAX_CELLS_Z = 32,
  parameter int INFLATE_MAX = 7,
  parameter int INFLATE_Z   = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  ivom_pkg::cfg_t     cfg,
  input  logic               req_valid,
  output logic               req_ready,
  input  ivom_pkg::item_in_t req,
  output logic               res_valid,
  input  logic               res_ready,
  output ivom_pkg::item_out_t res
);
  import ivom_pkg::*;

  localparam int XW    = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
  localparam int YW    = (MAX_CELLS_Y > 1) ? $clog2(MAX_CELLS_Y) : 1;
  localparam int ZW    = (MAX_CELLS_Z > 1) ? $clog2(MAX_CELLS_Z) : 1;
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int NZ_W  = $clog2(2 * INFLATE_Z + 2);

  localparam logic signed [CELL_W-1:0] LIM_X_MAX = CELL_W'(MAX_CELLS_X);
  localparam logic signed [CELL_W-1:0] LIM_Y_MAX = CELL_W'(MAX_CELLS_Y);
  localparam logic signed [CELL_W-1:0] LIM_Z_MAX = CELL_W'(MAX_CELLS_Z);
  localparam logic signed [CELL_W-1:0] R_MAX     = CELL_W'(INFLATE_MAX);
  localparam logic signed [CELL_W-1:0] R_Z       = CELL_W'(INFLATE_Z);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_CELL  = 7'b0001000,
    S_PLAN  = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_READ  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   done;

  item_in_t item;
  logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic signed [CELL_W-1:0] bx, by, bz;
  logic signed [CELL_W-1:0] cx, cy, y_lo, x_hi, y_hi;
  logic [MAX_CELLS_Z-1:0]   zmask;
  logic [NZ_W-1:0]          nz;
  logic [CNT_W-1:0]         cnt;
  logic                     hit_r, outside_r;
  logic                     pend_valid;
  logic [AW-1:0]            pend_addr;
  logic [AW-1:0]            clr_addr;
  logic                     clr_reply;

  logic [MAX_CELLS_Z-1:0] mem [DEPTH];
  logic [MAX_CELLS_Z-1:0] rdata;
  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [MAX_CELLS_Z-1:0] wr_data;

  logic signed [16:0]       diff_x, diff_y, diff_z;
  logic signed [CELL_W-1:0] lim_x, lim_y, lim_z, r_eff;
  logic signed [CELL_W-1:0] gx, gy, gz, infl;
  logic signed [CELL_W-1:0] z_lo, z_hi;
  logic [MAX_CELLS_Z-1:0]   zmask_c;
  logic [NZ_W-1:0]          nz_c;
  logic                     base_in, cur_in, sweep_end;
  logic [CNT_W:0]           cnt_sum;

  function automatic logic in_range(input logic signed [CELL_W-1:0] v,
                                    input logic signed [CELL_W-1:0] lim);
    return (v >= 0) && (v < lim);
  endfunction

  assign diff_x = $signed({item.pos_x[15], item.pos_x}) - $signed({cfg.origin_x[15], cfg.origin_x});
  assign diff_y = $signed({item.pos_y[15], item.pos_y}) - $signed({cfg.origin_y[15], cfg.origin_y});
  assign diff_z = $signed({item.pos_z[15], item.pos_z}) - $signed({cfg.origin_z[15], cfg.origin_z});

  assign gx    = CELL_W'(cfg.grid_cells_x);
  assign gy    = CELL_W'(cfg.grid_cells_y);
  assign gz    = CELL_W'(cfg.grid_cells_z);
  assign infl  = CELL_W'(cfg.inflate_cells);
  assign lim_x = (gx > LIM_X_MAX) ? LIM_X_MAX : gx;
  assign lim_y = (gy > LIM_Y_MAX) ? LIM_Y_MAX : gy;
  assign lim_z = (gz > LIM_Z_MAX) ? LIM_Z_MAX : gz;
  assign r_eff = (infl > R_MAX) ? R_MAX : infl;

  assign base_in   = in_range(bx, lim_x) && in_range(by, lim_y) && in_range(bz, lim_z);
  assign cur_in    = in_range(cx, lim_x) && in_range(cy, lim_y);
  assign sweep_end = (cx == x_hi) && (cy == y_hi);
  assign cnt_sum   = {1'b0, cnt} + (CNT_W + 1)'(nz);

  always_comb begin
    logic signed [CELL_W-1:0] zi;
    zmask_c = '0;
    for (int i = 0; i < MAX_CELLS_Z; i++) begin
      zi = CELL_W'(i);
      zmask_c[i] = (zi >= bz - R_Z) && (zi <= bz + R_Z) && (zi < lim_z);
    end
    z_lo = (bz - R_Z < 0) ? '0 : bz - R_Z;
    z_hi = (bz + R_Z > lim_z - 1) ? lim_z - 1 : bz + R_Z;
    nz_c = (z_hi >= z_lo) ? NZ_W'(z_hi - z_lo + 1) : '0;
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = {cx[XW-1:0], cy[YW-1:0]};
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = (req.cmd == CMD_CLEAR) ? S_CLEAR : S_MUL;
        end
      end
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = clr_reply ? S_READ : S_IDLE;
        end
      end
      S_MUL: state_next = S_CELL;
      S_CELL: state_next = S_PLAN;
      S_PLAN: begin
        case (item.cmd)
          CMD_INSERT: state_next = item.pos_z[15] ? S_READ : S_SWEEP;
          CMD_QUERY_POS, CMD_QUERY_CELL: begin
            rd_en      = base_in;
            rd_addr    = {bx[XW-1:0], by[YW-1:0]};
            state_next = S_READ;
          end
          default: state_next = S_READ;
        endcase
      end
      S_SWEEP: begin
        rd_en = cur_in;
        if (sweep_end) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        res_valid = done;
        if (done && res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign wr_en   = (state == S_CLEAR) || pend_valid;
  assign wr_addr = (state == S_CLEAR) ? clr_addr : pend_addr;
  assign wr_data = (state == S_CLEAR) ? '0 : (rdata | zmask);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == S_SWEEP) && cur_in;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_IDLE && req_valid) begin
        clr_reply <= (req.cmd == CMD_CLEAR);
        done      <= 1'b0;
      end
      if (state_next == S_READ && state != S_READ) begin
        done <= (state != S_PLAN) || !rd_en;
      end else if (state == S_READ) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          item      <= req;
          hit_r     <= 1'b0;
          outside_r <= 1'b0;
          cnt       <= '0;
        end
      end
      S_MUL: begin
        prod_x <= diff_x * $signed({1'b0, cfg.cells_per_metre});
        prod_y <= diff_y * $signed({1'b0, cfg.cells_per_metre});
        prod_z <= diff_z * $signed({1'b0, cfg.cells_per_metre});
      end
      S_CELL: begin
        if (item.cmd == CMD_QUERY_CELL) begin
          bx <= CELL_W'(item.cell_x);
          by <= CELL_W'(item.cell_y);
          bz <= CELL_W'(item.cell_z);
        end else begin
          bx <= prod_x[PROD_W-1:PROD_W-CELL_W];
          by <= prod_y[PROD_W-1:PROD_W-CELL_W];
          bz <= prod_z[PROD_W-1:PROD_W-CELL_W];
        end
      end
      S_PLAN: begin
        cx    <= bx - r_eff;
        cy    <= by - r_eff;
        y_lo  <= by - r_eff;
        x_hi  <= bx + r_eff;
        y_hi  <= by + r_eff;
        zmask <= zmask_c;
        nz    <= nz_c;
        if (item.cmd != CMD_INSERT || !item.pos_z[15]) begin
          outside_r <= !base_in;
        end
      end
      S_SWEEP: begin
        if (cur_in) begin
          pend_addr <= {cx[XW-1:0], cy[YW-1:0]};
          cnt <= (cnt_sum > (CNT_W + 1)'(MARK_SAT)) ? MARK_SAT : cnt_sum[CNT_W-1:0];
        end
        if (cy == y_hi) begin
          cy <= y_lo;
          cx <= cx + 1'b1;
        end else begin
          cy <= cy + 1'b1;
        end
      end
      S_READ: begin
        if (!done && (item.cmd == CMD_QUERY_POS || item.cmd == CMD_QUERY_CELL)) begin
          hit_r <= rdata[bz[ZW-1:0]];
        end
      end
      default: begin
      end
    endcase
  end

  assign res.hit          = hit_r;
  assign res.outside      = outside_r;
  assign res.cells_marked = cnt;

  `IVOM_ASSERT_SAME(a_rmw_no_overlap, wr_en && rd_en, wr_addr != rd_addr, "read and write hit one row")
  `IVOM_ASSERT_SAME(a_idle_quiet, state == S_IDLE, !wr_en && !pend_valid, "memory write while idle")
  `IVOM_ASSERT_SAME(a_hit_in_grid, res_valid && res.hit, !res.outside && res.cells_marked == '0,
                    "hit reported for a cell off the grid")
  `IVOM_ASSERT_NEXT(a_sweep_drains, state == S_SWEEP && sweep_end, state == S_READ && done,
                    "insert sweep did not close")

endmodule

`default_nettype wire

FILE: tb/inflated_voxel_occupancy_map_top_tb.sv
// Self-checking testbench for inflated_voxel_occupancy_map_top: a table of directed commands,
// then random commands under several map settings, checked against tabled or model results.
// Depends on ivom_pkg and the RTL of the block; reads no files.
`default_nettype none

module inflated_voxel_occupancy_map_top_tb;
  import ivom_pkg::*;

  localparam int MAP_X      = 64;
  localparam int MAP_Y      = 64;
  localparam int MAP_Z      = 32;
  localparam int RADIUS_MAX = 7;
  localparam int Z_REACH    = 2;
  localparam int N_DIRECTED = 25;

  typedef struct {
    item_in_t  cmd_item;
    bit        typed;
    item_out_t want;
  } dir_case_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  item_in_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  item_out_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit        in_take;
  bit        out_take;
  bit        cfg_take;
  item_out_t out_seen;

  bit        voxel_bits [0:MAP_X*MAP_Y*MAP_Z-1];
  cfg_t      map_cfg;
  item_out_t due_results [$];
  int        fail_count;
  dir_case_t dir_cases [0:N_DIRECTED-1];

  inflated_voxel_occupancy_map_top #(
    .MAX_CELLS_X(MAP_X),
    .MAX_CELLS_Y(MAP_Y),
    .MAX_CELLS_Z(MAP_Z),
    .INFLATE_MAX(RADIUS_MAX),
    .INFLATE_Z(Z_REACH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Handshake state is captured on the falling edge before the rising edge that acts on it.
  always @(negedge clk) begin
    in_take  = !rst && in_valid === 1'b1 && in_stall === 1'b0;
    out_take = !rst && out_valid === 1'b1 && out_stall === 1'b0;
    cfg_take = !rst && cfg_valid === 1'b1 && cfg_ready === 1'b1;
    out_seen = out_item;
  end

  function automatic int axis_lim(int g, int m);
    return (g > m) ? m : g;
  endfunction

  function automatic bit in_grid(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 &&
           x < axis_lim(map_cfg.grid_cells_x, MAP_X) &&
           y < axis_lim(map_cfg.grid_cells_y, MAP_Y) &&
           z < axis_lim(map_cfg.grid_cells_z, MAP_Z);
  endfunction

  function automatic int voxel_addr(int x, int y, int z);
    return x * MAP_Y * MAP_Z + y * MAP_Z + z;
  endfunction

  function automatic int cell_of(logic signed [15:0] pos, logic signed [15:0] org);
    longint scaled;
    scaled = (longint'(pos) - longint'(org)) * longint'(map_cfg.cells_per_metre);
    return int'(scaled >>> 8);
  endfunction

  function automatic item_out_t probe_cell(int x, int y, int z);
    item_out_t res;
    res = '0;
    res.outside = !in_grid(x, y, z);
    if (!res.outside) res.hit = voxel_bits[voxel_addr(x, y, z)];
    return res;
  endfunction

  function automatic item_out_t run_command(item_in_t it);
    item_out_t res;
    int bx, by, bz, r, n;
    res = '0;
    case (it.cmd)
      CMD_CLEAR: begin
        foreach (voxel_bits[i]) voxel_bits[i] = 1'b0;
      end
      CMD_INSERT: begin
        if (!it.pos_z[15]) begin
          bx = cell_of(it.pos_x, map_cfg.origin_x);
          by = cell_of(it.pos_y, map_cfg.origin_y);
          bz = cell_of(it.pos_z, map_cfg.origin_z);
          r = (map_cfg.inflate_cells > RADIUS_MAX) ? RADIUS_MAX : map_cfg.inflate_cells;
          n = 0;
          res.outside = !in_grid(bx, by, bz);
          for (int dx = -r; dx <= r; dx++)
            for (int dy = -r; dy <= r; dy++)
              for (int dz = -Z_REACH; dz <= Z_REACH; dz++)
                if (in_grid(bx + dx, by + dy, bz + dz)) begin
                  voxel_bits[voxel_addr(bx + dx, by + dy, bz + dz)] = 1'b1;
                  if (n < MARK_SAT) n++;
                end
          res.cells_marked = CNT_W'(n);
        end
      end
      CMD_QUERY_POS: begin
        res = probe_cell(cell_of(it.pos_x, map_cfg.origin_x),
                         cell_of(it.pos_y, map_cfg.origin_y),
                         cell_of(it.pos_z, map_cfg.origin_z));
      end
      default: begin
        res = probe_cell(int'(it.cell_x), int'(it.cell_y), int'(it.cell_z));
      end
    endcase
    return res;
  endfunction

  function automatic cfg_t map_settings(int cpm, int ox, int oy, int oz,
                                        int gx, int gy, int gz, int infl);
    cfg_t c;
    c.cells_per_metre = 8'(cpm);
    c.origin_x        = 16'(ox);
    c.origin_y        = 16'(oy);
    c.origin_z        = 16'(oz);
    c.grid_cells_x    = 7'(gx);
    c.grid_cells_y    = 7'(gy);
    c.grid_cells_z    = 6'(gz);
    c.inflate_cells   = 3'(infl);
    return c;
  endfunction

  function automatic dir_case_t dir_case(cmd_t cmd, int px, int py, int pz, int cx, int cy,
                                         int cz, bit typed, bit hit, bit outside, int marked);
    dir_case_t d;
    d.cmd_item.cmd          = cmd;
    d.cmd_item.pos_x        = 16'(px);
    d.cmd_item.pos_y        = 16'(py);
    d.cmd_item.pos_z        = 16'(pz);
    d.cmd_item.cell_x       = 8'(cx);
    d.cmd_item.cell_y       = 8'(cy);
    d.cmd_item.cell_z       = 8'(cz);
    d.typed                 = typed;
    d.want.hit              = hit;
    d.want.outside          = outside;
    d.want.cells_marked     = CNT_W'(marked);
    return d;
  endfunction

  // A position that lands a few cells around the grid on one axis.
  function automatic logic [15:0] near_pos(logic signed [15:0] org, int lim);
    int cpm, c, v;
    cpm = map_cfg.cells_per_metre;
    if (cpm == 0) return 16'($urandom);
    c = $urandom_range(0, lim + 9) - 5;
    v = int'(org) + c * 256 / cpm + int'($urandom_range(0, 255 / cpm));
    return v[15:0];
  endfunction

  function automatic item_in_t random_command();
    item_in_t it;
    int sel, lx, ly, lz;
    it.pos_x  = 16'($urandom);
    it.pos_y  = 16'($urandom);
    it.pos_z  = 16'($urandom);
    it.cell_x = 8'($urandom);
    it.cell_y = 8'($urandom);
    it.cell_z = 8'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 4) it.cmd = CMD_CLEAR;
    else if (sel < 40) it.cmd = CMD_INSERT;
    else if (sel < 70) it.cmd = CMD_QUERY_POS;
    else it.cmd = CMD_QUERY_CELL;
    lx = axis_lim(map_cfg.grid_cells_x, MAP_X);
    ly = axis_lim(map_cfg.grid_cells_y, MAP_Y);
    lz = axis_lim(map_cfg.grid_cells_z, MAP_Z);
    if ($urandom_range(0, 4) != 0) begin
      it.pos_x  = near_pos(map_cfg.origin_x, lx);
      it.pos_y  = near_pos(map_cfg.origin_y, ly);
      it.pos_z  = near_pos(map_cfg.origin_z, lz);
      it.cell_x = 8'($urandom_range(0, lx + 3) - 2);
      it.cell_y = 8'($urandom_range(0, ly + 3) - 2);
      it.cell_z = 8'($urandom_range(0, lz + 3) - 2);
    end
    if (it.cmd == CMD_INSERT && $urandom_range(0, 19) == 0) it.pos_z[15] = 1'b1;
    return it;
  endfunction

  task automatic send_command(item_in_t it, item_out_t fixed, bit use_fixed);
    int gap;
    item_out_t pred;
    case ($urandom_range(0, 9))
      0: gap = $urandom_range(30, 200);
      1, 2, 3, 4: gap = $urandom_range(1, 6);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_take);
    pred = run_command(it);
    due_results.insert(due_results.size(), use_fixed ? fixed : pred);
  endtask

  task automatic send_random(int count);
    repeat (count) send_command(random_command(), '0, 1'b0);
  endtask

  task automatic drain(int settle);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_take);
    case (idx)
      REG_CELLS_PER_METRE: map_cfg.cells_per_metre = data[7:0];
      REG_ORIGIN_X:        map_cfg.origin_x        = data;
      REG_ORIGIN_Y:        map_cfg.origin_y        = data;
      REG_ORIGIN_Z:        map_cfg.origin_z        = data;
      REG_GRID_CELLS_X:    map_cfg.grid_cells_x    = data[6:0];
      REG_GRID_CELLS_Y:    map_cfg.grid_cells_y    = data[6:0];
      REG_GRID_CELLS_Z:    map_cfg.grid_cells_z    = data[5:0];
      REG_INFLATE_CELLS:   map_cfg.inflate_cells   = data[2:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry noise; the registers keep only their own width.
  task automatic program_map(cfg_t c);
    put_reg(REG_CELLS_PER_METRE, {8'($urandom), c.cells_per_metre});
    put_reg(REG_ORIGIN_X, c.origin_x);
    put_reg(REG_ORIGIN_Y, c.origin_y);
    put_reg(REG_ORIGIN_Z, c.origin_z);
    put_reg(REG_GRID_CELLS_X, {9'($urandom), c.grid_cells_x});
    put_reg(REG_GRID_CELLS_Y, {9'($urandom), c.grid_cells_y});
    put_reg(REG_GRID_CELLS_Z, {10'($urandom), c.grid_cells_z});
    put_reg(REG_INFLATE_CELLS, {13'($urandom), c.inflate_cells});
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    item_out_t want;
    if (out_take) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected: hit %0b outside %0b cells_marked %0d",
                 $time, out_seen.hit, out_seen.outside, out_seen.cells_marked);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (out_seen.hit !== want.hit) begin
          $display("%0t: hit expected %0b, got %0b", $time, want.hit, out_seen.hit);
          fail_count++;
        end
        if (out_seen.outside !== want.outside) begin
          $display("%0t: outside expected %0b, got %0b", $time, want.outside, out_seen.outside);
          fail_count++;
        end
        if (out_seen.cells_marked !== want.cells_marked) begin
          $display("%0t: cells_marked expected %0d, got %0d", $time, want.cells_marked,
                   out_seen.cells_marked);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int open_len, hold_len;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      open_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 600) : $urandom_range(1, 40);
      hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 200) : $urandom_range(1, 4);
      repeat (open_len) @(posedge clk);
      out_stall <= 1'b1;
      repeat (hold_len) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    fail_count = 0;
    map_cfg    = map_settings(20, -3328, -2560, -256, 64, 64, 32, 4);

    dir_cases[0]  = dir_case(CMD_QUERY_CELL, -32768, 32767, -1, 0, 0, 0, 1, 0, 0, 0);
    dir_cases[1]  = dir_case(CMD_QUERY_CELL, 0, 0, 0, 63, 63, 31, 1, 0, 0, 0);
    dir_cases[2]  = dir_case(CMD_QUERY_CELL, 32767, -32768, 32767, 64, 0, 0, 1, 0, 1, 0);
    dir_cases[3]  = dir_case(CMD_QUERY_CELL, 0, 0, 0, 0, 0, -1, 1, 0, 1, 0);
    dir_cases[4]  = dir_case(CMD_QUERY_CELL, -1, -1, -1, -128, -128, -128, 1, 0, 1, 0);
    dir_cases[5]  = dir_case(CMD_QUERY_CELL, 0, 0, 0, 127, 127, 127, 1, 0, 1, 0);
    dir_cases[6]  = dir_case(CMD_INSERT, -3328, -2560, -1, 127, -128, -1, 1, 0, 0, 0);
    dir_cases[7]  = dir_case(CMD_INSERT, 0, 0, -32768, 0, 0, 0, 1, 0, 0, 0);
    dir_cases[8]  = dir_case(CMD_INSERT, -3328, -2560, 0, 0, 0, 0, 1, 0, 0, 125);
    dir_cases[9]  = dir_case(CMD_QUERY_CELL, 0, 0, 0, 4, 4, 22, 1, 1, 0, 0);
    dir_cases[10] = dir_case(CMD_QUERY_CELL, 0, 0, 0, 0, 0, 18, 1, 1, 0, 0);
    dir_cases[11] = dir_case(CMD_QUERY_CELL, 0, 0, 0, 5, 0, 20, 1, 0, 0, 0);
    dir_cases[12] = dir_case(CMD_INSERT, -2944, -2176, 64, -128, 127, 0, 1, 0, 0, 405);
    dir_cases[13] = dir_case(CMD_QUERY_POS, -2944, -2176, 64, 0, 0, 0, 1, 1, 0, 0);
    dir_cases[14] = dir_case(CMD_INSERT, -2521, -1753, 141, 0, 0, 0, 1, 0, 0, 75);
    dir_cases[15] = dir_case(CMD_QUERY_POS, -2521, -1753, 141, 127, 127, 127, 1, 1, 0, 0);
    dir_cases[16] = dir_case(CMD_QUERY_POS, -3329, -2560, 0, 0, 0, 0, 1, 0, 1, 0);
    dir_cases[17] = dir_case(CMD_QUERY_POS, 32767, -32768, 0, 0, 0, 0, 1, 0, 1, 0);
    dir_cases[18] = dir_case(CMD_INSERT, 32767, 32767, 32767, 0, 0, 0, 1, 0, 1, 0);
    dir_cases[19] = dir_case(CMD_INSERT, -32768, -32768, 0, 0, 0, 0, 1, 0, 1, 0);
    dir_cases[20] = dir_case(CMD_INSERT, -3000, -2000, 200, 0, 0, 0, 0, 0, 0, 0);
    dir_cases[21] = dir_case(CMD_QUERY_POS, -3000, -2000, 200, 0, 0, 0, 0, 0, 0, 0);
    dir_cases[22] = dir_case(CMD_CLEAR, 32767, 32767, 32767, -128, -128, -128, 1, 0, 0, 0);
    dir_cases[23] = dir_case(CMD_QUERY_CELL, 0, 0, 0, 4, 4, 22, 1, 0, 0, 0);
    dir_cases[24] = dir_case(CMD_QUERY_CELL, 0, 0, 0, 30, 30, 25, 1, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_cases[k]) send_command(dir_cases[k].cmd_item, dir_cases[k].want, dir_cases[k].typed);
    send_random(120);

    drain(8);
    program_map(map_settings(255, 0, 0, 0, 64, 64, 32, 7));
    send_random(100);

    drain(8);
    program_map(map_settings(1, -32768, -32768, -2048, 127, 100, 63, 0));
    send_random(90);

    // Zero scale folds every position onto cell zero of a single-cell grid.
    drain(8);
    program_map(map_settings(0, 32767, 32767, -32768, 1, 1, 1, 3));
    send_random(50);

    drain(8);
    program_map(map_settings(37, 100, -500, 32767, 0, 20, 10, 2));
    send_random(50);

    repeat (2) begin
      drain(8);
      program_map(map_settings($urandom_range(1, 255), $urandom_range(0, 4000) - 2000,
                               $urandom_range(0, 4000) - 2000, -$urandom_range(0, 512),
                               $urandom_range(1, 64), $urandom_range(1, 64),
                               $urandom_range(1, 32), $urandom_range(0, 7)));
      send_random(120);
    end

    drain(300);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: inflated_voxel_occupancy_map_top.f
+incdir+sv
sv/ivom_pkg.sv
sv/ivom_map.sv
sv/inflated_voxel_occupancy_map_top.sv
tb/inflated_voxel_occupancy_map_top_tb.sv
